// ----- sv/bmp_pixel_stream_to_rgb555_unit_defines.svh -----
// Assertion helpers for the checker file of the unit.
`ifndef BMP_PIXEL_STREAM_TO_RGB555_UNIT_DEFINES_SVH
`define BMP_PIXEL_STREAM_TO_RGB555_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define BMP_RGB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is also checked during reset.
`define BMP_RGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ----- sv/bmp_rgb_pkg.sv -----
package bmp_rgb_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int BYTE_W     = 8;
   localparam int POS_W      = 12;
   localparam int CH_W       = 5;
   localparam int GEOM_W     = 13;
   localparam int MASK_W     = 32;
   localparam int PIX_W      = 16;
   localparam int BITS_W     = 6;
   localparam int SIZE_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RED_MASK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN_MASK   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BLUE_MASK    = 3'd5;

   // Pixel formats
   localparam logic FMT_BGR24  = 1'b0;
   localparam logic FMT_MASK16 = 1'b1;

   localparam logic [MASK_W-1:0] RED_MASK_RESET   = 32'h0000_7c00;
   localparam logic [MASK_W-1:0] GREEN_MASK_RESET = 32'h0000_03e0;
   localparam logic [MASK_W-1:0] BLUE_MASK_RESET  = 32'h0000_001f;
   localparam logic [BITS_W-1:0] MASK_BITS_RESET  = 6'd5;

   typedef struct packed {
      logic              pixel_format;
      logic [MASK_W-1:0] red_mask;
      logic [MASK_W-1:0] green_mask;
      logic [MASK_W-1:0] blue_mask;
      logic [BITS_W-1:0] red_bits;
      logic [BITS_W-1:0] green_bits;
      logic [BITS_W-1:0] blue_bits;
   } cfg_type;

   function automatic logic [BITS_W-1:0] popcount32(input logic [MASK_W-1:0] v);
      logic [1:0] l1 [16];
      logic [2:0] l2 [8];
      logic [3:0] l3 [4];
      logic [4:0] l4 [2];
      for (int i = 0; i < 16; i++) l1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
      for (int i = 0; i < 8; i++)  l2[i] = 3'(l1[2*i]) + 3'(l1[2*i+1]);
      for (int i = 0; i < 4; i++)  l3[i] = 4'(l2[2*i]) + 4'(l2[2*i+1]);
      for (int i = 0; i < 2; i++)  l4[i] = 5'(l3[2*i]) + 5'(l3[2*i+1]);
      return 6'(l4[0]) + 6'(l4[1]);
   endfunction

   // Scale a component to five bits given the set-bit count of its mask.
   function automatic logic [CH_W-1:0] to_five(input logic [PIX_W-1:0] comp,
                                               input logic [BITS_W-1:0] bits);
      logic [BITS_W-1:0] sh_dn;
      logic [2:0]        sh_up;
      logic [PIX_W-1:0]  t;
      sh_dn = '0;
      sh_up = '0;
      if (bits > 6'd5) begin
         sh_dn = bits - 6'd5;
         t     = comp >> sh_dn;
      end else begin
         sh_up = 3'(6'd5 - bits);
         t     = comp << sh_up;
      end
      return t[CH_W-1:0];
   endfunction

   // Size minus one, with zero taken as one and saturation at the bound.
   function automatic logic [SIZE_W-1:0] eff_size_m1(input logic [GEOM_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max_size);
      logic [SIZE_W-1:0] v16;
      v16 = SIZE_W'(v);
      if (v16 == '0) return '0;
      if (v16 > max_size) return max_size - 16'd1;
      return v16 - 16'd1;
   endfunction

endpackage

// ----- sv/bmp_rgb_req_if.sv -----
interface bmp_rgb_req_if;
   import bmp_rgb_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- sv/bmp_rgb_rsp_if.sv -----
interface bmp_rgb_rsp_if;
   import bmp_rgb_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [CH_W-1:0]  red;
   logic [CH_W-1:0]  green;
   logic [CH_W-1:0]  blue;
   logic             last_pixel;

   modport source (output valid, output pos_x, output pos_y, output red, output green,
                   output blue, output last_pixel, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input red, input green,
                   input blue, input last_pixel, output ready);
endinterface

// ----- sv/bmp_rgb_cfg.sv -----
module bmp_rgb_cfg #(
   parameter int MAX_WIDTH  = bmp_rgb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmp_rgb_pkg::DEF_MAX_HEIGHT,
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bmp_rgb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bmp_rgb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bmp_rgb_pkg::cfg_type                cfg,
   output logic [CW-1:0]                       width_m1,
   output logic [RW-1:0]                       height_m1,
   output logic                                restart
);
   import bmp_rgb_pkg::*;

   cfg_type       cfg_ff;
   logic [CW-1:0] width_m1_ff;
   logic [RW-1:0] height_m1_ff;
   logic          restart_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= FMT_BGR24;
         cfg_ff.red_mask     <= RED_MASK_RESET;
         cfg_ff.green_mask   <= GREEN_MASK_RESET;
         cfg_ff.blue_mask    <= BLUE_MASK_RESET;
         cfg_ff.red_bits     <= MASK_BITS_RESET;
         cfg_ff.green_bits   <= MASK_BITS_RESET;
         cfg_ff.blue_bits    <= MASK_BITS_RESET;
         width_m1_ff         <= '0;
         height_m1_ff        <= '0;
         restart_ff          <= 1'b0;
      end else begin
         restart_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               REG_PIXEL_FORMAT: begin
                  cfg_ff.pixel_format <= csr_wdata[0];
                  restart_ff          <= 1'b1;
               end
               REG_IMAGE_WIDTH: begin
                  width_m1_ff <= CW'(eff_size_m1(csr_wdata[GEOM_W-1:0],
                                                 SIZE_W'(MAX_WIDTH)));
                  restart_ff  <= 1'b1;
               end
               REG_IMAGE_HEIGHT: begin
                  height_m1_ff <= RW'(eff_size_m1(csr_wdata[GEOM_W-1:0],
                                                  SIZE_W'(MAX_HEIGHT)));
                  restart_ff   <= 1'b1;
               end
               REG_RED_MASK: begin
                  cfg_ff.red_mask <= csr_wdata;
                  cfg_ff.red_bits <= popcount32(csr_wdata);
               end
               REG_GREEN_MASK: begin
                  cfg_ff.green_mask <= csr_wdata;
                  cfg_ff.green_bits <= popcount32(csr_wdata);
               end
               REG_BLUE_MASK: begin
                  cfg_ff.blue_mask <= csr_wdata;
                  cfg_ff.blue_bits <= popcount32(csr_wdata);
               end
               default: ;
            endcase
         end
      end
   end

   assign cfg       = cfg_ff;
   assign width_m1  = width_m1_ff;
   assign height_m1 = height_m1_ff;
   assign restart   = restart_ff;

endmodule

// ----- sv/bmp_pixel_stream_to_rgb555_unit.sv -----
// Decodes the pixel-data area of a bottom-up BMP, one byte per transfer, into
// one five-bit-per-channel pixel per 24-bit triple or 16-bit halfword, with
// column, row (counting down from height minus one) and a last-pixel flag; row
// padding bytes are consumed silently. A byte can be taken every cycle unless a
// stalled result holds the input register; a pixel's final byte lands in the
// input register at its transfer, and the decode logic then loads the result
// register from it once the result register is free. Writing the format, width or
// height restarts the image; mask writes take effect at once. Mask bit counts
// are computed when a mask is written.
module bmp_pixel_stream_to_rgb555_unit #(
   parameter int MAX_WIDTH  = bmp_rgb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmp_rgb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bmp_rgb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bmp_rgb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   bmp_rgb_req_if.sink                         req_chan,
   bmp_rgb_rsp_if.source                       rsp_chan
);
   import bmp_rgb_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   cfg_type       cfg;
   logic [CW-1:0] width_m1;
   logic [RW-1:0] height_m1;
   logic          restart;

   bmp_rgb_cfg #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg),
      .width_m1 (width_m1),
      .height_m1(height_m1),
      .restart  (restart)
   );

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;

   // Decode state
   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] held_lo_ff, held_lo_in;
   logic [BYTE_W-1:0] held_hi_ff, held_hi_in;
   logic [CW-1:0]     column_ff, column_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [1:0]        pad_ff, pad_in;

   // Result register
   logic             out_valid_ff, out_valid_in;
   logic [POS_W-1:0] out_x_ff, out_y_ff;
   logic [CH_W-1:0]  out_r_ff, out_g_ff, out_b_ff;
   logic             out_last_ff;

   logic             fmt16, pad_busy, emit, out_free, advance, req_xfer;
   logic             col_last, is_last;
   logic [1:0]       wl, pad_next;
   logic [PIX_W-1:0] px;
   logic [6:0]       red_shift;
   logic [CH_W-1:0]  r5, g5, b5;

   assign fmt16    = (cfg.pixel_format == FMT_MASK16);
   assign pad_busy = (pad_ff != 2'd0);
   assign emit     = s1_valid_ff && !pad_busy &&
                     (fmt16 ? (phase_ff != 2'd0) : (phase_ff >= 2'd2));
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = s1_valid_ff && (!emit || out_free);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_xfer = req_chan.valid && req_chan.ready;

   // Row byte count mod 4 decides padding: 3w pads by w, 2w by 2*w[0].
   assign wl       = 2'(width_m1) + 2'd1;
   assign pad_next = fmt16 ? {wl[0], 1'b0} : wl;
   assign col_last = (column_ff == width_m1);
   assign is_last  = (row_ff == '0) && col_last;

   assign px        = {s1_byte_ff, held_lo_ff};
   assign red_shift = 7'(cfg.blue_bits) + 7'(cfg.green_bits);

   always_comb begin
      if (fmt16) begin
         b5 = to_five(px & cfg.blue_mask[PIX_W-1:0], cfg.blue_bits);
         g5 = to_five((px & cfg.green_mask[PIX_W-1:0]) >> cfg.blue_bits, cfg.green_bits);
         r5 = to_five((px & cfg.red_mask[PIX_W-1:0]) >> red_shift, cfg.red_bits);
      end else begin
         b5 = held_lo_ff[BYTE_W-1:BYTE_W-CH_W];
         g5 = held_hi_ff[BYTE_W-1:BYTE_W-CH_W];
         r5 = s1_byte_ff[BYTE_W-1:BYTE_W-CH_W];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      held_lo_in = held_lo_ff;
      held_hi_in = held_hi_ff;
      column_in  = column_ff;
      row_in     = row_ff;
      pad_in     = pad_ff;
      if (restart) begin
         phase_in  = 2'd0;
         column_in = '0;
         row_in    = height_m1;
         pad_in    = 2'd0;
      end else if (advance) begin
         if (pad_busy) begin
            // drop a padding byte
            pad_in = pad_ff - 2'd1;
         end else if (!emit) begin
            if (fmt16 || phase_ff == 2'd0) begin
               held_lo_in = s1_byte_ff;
            end else begin
               held_hi_in = s1_byte_ff;
            end
            phase_in = phase_ff + 2'd1;
         end else begin
            phase_in = 2'd0;
            if (col_last) begin
               column_in = '0;
               pad_in    = pad_next;
               row_in    = (row_ff == '0) ? height_m1 : row_ff - RW'(1);
            end else begin
               column_in = column_ff + CW'(1);
            end
         end
      end
   end

   assign out_valid_in = out_free ? emit : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 2'd0;
         column_ff    <= '0;
         row_ff       <= '0;
         pad_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         pad_ff       <= pad_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_lo_ff <= held_lo_in;
      held_hi_ff <= held_hi_in;
      if (req_xfer) begin
         s1_byte_ff <= req_chan.data_byte;
      end
      if (emit && out_free) begin
         out_x_ff    <= POS_W'(column_ff);
         out_y_ff    <= POS_W'(row_ff);
         out_r_ff    <= r5;
         out_g_ff    <= g5;
         out_b_ff    <= b5;
         out_last_ff <= is_last;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pos_x      = out_x_ff;
   assign rsp_chan.pos_y      = out_y_ff;
   assign rsp_chan.red        = out_r_ff;
   assign rsp_chan.green      = out_g_ff;
   assign rsp_chan.blue       = out_b_ff;
   assign rsp_chan.last_pixel = out_last_ff;

endmodule

// ----- sv/bmp_rgb_checker.sv -----
`include "bmp_pixel_stream_to_rgb555_unit_defines.svh"

module bmp_rgb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bmp_rgb_pkg::POS_W-1:0] rsp_pos_x,
   input logic [bmp_rgb_pkg::POS_W-1:0] rsp_pos_y,
   input logic [bmp_rgb_pkg::CH_W-1:0]  rsp_red,
   input logic [bmp_rgb_pkg::CH_W-1:0]  rsp_green,
   input logic [bmp_rgb_pkg::CH_W-1:0]  rsp_blue,
   input logic                          rsp_last_pixel
);
   import bmp_rgb_pkg::*;

   // hold a stalled result
   `BMP_RGB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_last_pixel), "stalled result changed")

   // the last pixel of a bottom-up image sits in row zero
   `BMP_RGB_ASSERT(a_last_row, clock, reset, rsp_valid && rsp_last_pixel |-> rsp_pos_y == '0, "last pixel outside row zero")

   `BMP_RGB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind bmp_pixel_stream_to_rgb555_unit bmp_rgb_checker u_bmp_rgb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_pos_x     (rsp_chan.pos_x),
   .rsp_pos_y     (rsp_chan.pos_y),
   .rsp_red       (rsp_chan.red),
   .rsp_green     (rsp_chan.green),
   .rsp_blue      (rsp_chan.blue),
   .rsp_last_pixel(rsp_chan.last_pixel)
);

// ----- bench/tb_bmp_pixel_stream_to_rgb555_unit.sv -----
module tb_bmp_pixel_stream_to_rgb555_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bmp_rgb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_TARGET = 1400;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic             last_pixel;
   } pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bmp_rgb_req_if req_if ();
   bmp_rgb_rsp_if rsp_if ();

   bmp_pixel_stream_to_rgb555_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // Decoder image of the block: configuration and stream position
   logic              dec_fmt;
   logic [GEOM_W-1:0] dec_width;
   logic [GEOM_W-1:0] dec_height;
   logic [MASK_W-1:0] dec_red_mask;
   logic [MASK_W-1:0] dec_green_mask;
   logic [MASK_W-1:0] dec_blue_mask;
   int unsigned       dec_phase;
   logic [15:0]       dec_held;
   int unsigned       dec_col;
   int unsigned       dec_row;
   int unsigned       dec_pad;

   pixel_type pixels_due[$];

   int error_count   = 0;
   int byte_count    = 0;
   int cycle_count   = 0;
   int rsp_hold_left = 0;
   bit req_idle_on   = 1'b1;
   bit rsp_idle_on   = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   function automatic int unsigned clamp_dim(input logic [GEOM_W-1:0] v,
                                             input int unsigned bound);
      if (v == '0) return 1;
      if (v > bound) return bound;
      return v;
   endfunction

   function automatic logic [31:0] shift_down(input logic [31:0] v, input int unsigned s);
      return (s >= 32) ? 32'h0 : (v >> s);
   endfunction

   function automatic logic [CH_W-1:0] scale5(input logic [31:0] comp,
                                              input int unsigned bits);
      logic [31:0] t;
      if (bits > 5) t = shift_down(comp, bits - 5);
      else t = comp << (5 - bits);
      return t[CH_W-1:0];
   endfunction

   function automatic void restart_image();
      dec_phase = 0;
      dec_held  = '0;
      dec_col   = 0;
      dec_row   = clamp_dim(dec_height, DEF_MAX_HEIGHT) - 1;
      dec_pad   = 0;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_PIXEL_FORMAT: begin
            dec_fmt = data[0];
            restart_image();
         end
         REG_IMAGE_WIDTH: begin
            dec_width = data[GEOM_W-1:0];
            restart_image();
         end
         REG_IMAGE_HEIGHT: begin
            dec_height = data[GEOM_W-1:0];
            restart_image();
         end
         REG_RED_MASK:   dec_red_mask = data;
         REG_GREEN_MASK: dec_green_mask = data;
         REG_BLUE_MASK:  dec_blue_mask = data;
         default: ;
      endcase
   endfunction

   // Advance the decoder by one accepted byte; queue the pixel it completes.
   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      logic [31:0] px;
      int unsigned nb, ng, nr, w, row_bytes;
      pixel_type pix;
      if (dec_pad != 0) begin
         dec_pad--;
         return;
      end
      if (dec_fmt == FMT_BGR24) begin
         if (dec_phase < 2) begin
            if (dec_phase == 0) dec_held[7:0] = b;
            else dec_held[15:8] = b;
            dec_phase++;
            return;
         end
         pix.blue  = dec_held[7:3];
         pix.green = dec_held[15:11];
         pix.red   = b[7:3];
      end else begin
         if (dec_phase == 0) begin
            dec_held  = {8'h00, b};
            dec_phase = 1;
            return;
         end
         px = {16'h0000, b, dec_held[7:0]};
         nb = $countones(dec_blue_mask);
         ng = $countones(dec_green_mask);
         nr = $countones(dec_red_mask);
         pix.blue  = scale5(px & dec_blue_mask, nb);
         pix.green = scale5(shift_down(px & dec_green_mask, nb), ng);
         pix.red   = scale5(shift_down(px & dec_red_mask, nb + ng), nr);
      end
      dec_phase = 0;
      dec_held  = '0;
      w = clamp_dim(dec_width, DEF_MAX_WIDTH);
      pix.pos_x      = POS_W'(dec_col);
      pix.pos_y      = POS_W'(dec_row);
      pix.last_pixel = (dec_row == 0) && (dec_col + 1 >= w);
      pixels_due.push_back(pix);
      dec_col++;
      if (dec_col >= w) begin
         row_bytes = (dec_fmt == FMT_BGR24) ? w * 3 : w * 2;
         dec_col = 0;
         dec_pad = (4 - (row_bytes & 3)) & 3;
         dec_row = (dec_row == 0) ? clamp_dim(dec_height, DEF_MAX_HEIGHT) - 1 : dec_row - 1;
      end
   endfunction

   function automatic int image_bytes();
      int unsigned w, row_bytes;
      w = clamp_dim(dec_width, DEF_MAX_WIDTH);
      row_bytes = (dec_fmt == FMT_BGR24) ? w * 3 : w * 2;
      row_bytes += (4 - (row_bytes & 3)) & 3;
      return row_bytes * clamp_dim(dec_height, DEF_MAX_HEIGHT);
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic check_pixel();
      pixel_type want;
      if (pixels_due.size() == 0) begin
         $error("unexpected pixel transfer at x=%0d y=%0d", rsp_if.pos_x, rsp_if.pos_y);
         error_count++;
         return;
      end
      want = pixels_due.pop_front();
      compare_field("pos_x", want.pos_x, rsp_if.pos_x);
      compare_field("pos_y", want.pos_y, rsp_if.pos_y);
      compare_field("red", want.red, rsp_if.red);
      compare_field("green", want.green, rsp_if.green);
      compare_field("blue", want.blue, rsp_if.blue);
      compare_field("last_pixel", want.last_pixel, rsp_if.last_pixel);
   endtask

   // Result side: check each transfer, then stall or hold off before the next.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            check_pixel();
            stall_left = rsp_idle_on ? $urandom_range(0, 3) : 0;
         end
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_if.ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid     = 1'b1;
      req_if.data_byte = value;
      do @(posedge clock); while (!req_if.ready);
      decode_byte(value);
      byte_count++;
   endtask

   task automatic send_random(input int n);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Drop valid, wait for every pixel due, then let the pipeline settle.
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      apply_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] fmt,
                               input logic [CSR_DATA_W-1:0] w,
                               input logic [CSR_DATA_W-1:0] h);
      write_reg(REG_PIXEL_FORMAT, fmt);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   task automatic set_masks(input logic [MASK_W-1:0] r, input logic [MASK_W-1:0] g,
                            input logic [MASK_W-1:0] b);
      write_reg(REG_RED_MASK, r);
      write_reg(REG_GREEN_MASK, g);
      write_reg(REG_BLUE_MASK, b);
   endtask

   function automatic logic [MASK_W-1:0] corner_mask();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h0000_ffff;
         3: return 32'h8000_0000;
         default: return 32'h0000_0001;
      endcase
   endfunction

   task automatic choose_masks();
      logic [MASK_W-1:0] r, g, b;
      int unsigned bw, gw, rw;
      case ($urandom_range(0, 5))
         0: begin
            r = RED_MASK_RESET;
            g = GREEN_MASK_RESET;
            b = BLUE_MASK_RESET;
         end
         1: begin
            r = 32'h0000_f800;
            g = 32'h0000_07e0;
            b = 32'h0000_001f;
         end
         2: begin
            // contiguous fields packed upward from bit 0
            bw = $urandom_range(0, 8);
            gw = $urandom_range(0, 8);
            rw = $urandom_range(0, 10);
            b = MASK_W'((64'd1 << bw) - 64'd1);
            g = MASK_W'(((64'd1 << gw) - 64'd1) << bw);
            r = MASK_W'(((64'd1 << rw) - 64'd1) << (bw + gw));
         end
         3: begin
            r = $urandom;
            g = $urandom;
            b = $urandom;
         end
         4: begin
            r = $urandom & 32'h0000_ffff;
            g = $urandom & 32'h0000_ffff;
            b = $urandom & 32'h0000_ffff;
         end
         default: begin
            r = corner_mask();
            g = corner_mask();
            b = corner_mask();
         end
      endcase
      set_masks(r, g, b);
   endtask

   // Reset values: 24-bit, one pixel per image, one padding byte per row.
   task automatic test_reset_defaults();
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(8'hff);
      wait_idle();
   endtask

   // 16-bit with reset masks; format and sizes written with stray upper bits,
   // zero width and height taken as one.
   task automatic test_halfword_defaults();
      set_geometry(32'hffff_ffff, 32'hffff_e000, 32'h0000_0000);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'ha5);
      send_byte(8'h5a);
      send_byte(8'hff);
      send_byte(8'hff);
      wait_idle();
   endtask

   // 565, oversize shifts, wide components; mask writes mid-row do not restart.
   task automatic test_mask_layouts();
      set_geometry(FMT_MASK16, 2, 1);
      set_masks(32'h0000_f800, 32'h0000_07e0, 32'h0000_001f);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'h80);
      wait_idle();
      set_masks(32'hffff_0000, 32'hffff_ffff, 32'h0000_0000);
      send_byte(8'h34);
      send_byte(8'h12);
      wait_idle();
      set_masks(32'h0000_ffe0, 32'h0000_001c, 32'h0000_0003);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(8'h0b);
      send_byte(8'ha9);
      wait_idle();
      set_masks(32'h0000_00f8, 32'h0000_0007, 32'hffff_ffff);
      send_byte(8'hff);
      send_byte(8'hff);
      wait_idle();
   endtask

   // Largest sizes and saturation above them; a few pixels only.
   task automatic test_size_extremes();
      set_geometry(FMT_BGR24, 4096, 4096);
      send_random(3);
      wait_idle();
      set_geometry(FMT_BGR24, 32'h0000_1fff, 32'h0000_1fff);
      send_random(6);
      wait_idle();
   endtask

   // Hold the result side off while bytes keep coming, so the input stalls.
   task automatic test_back_pressure();
      set_geometry(FMT_MASK16, 2, 3);
      set_masks(RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET);
      req_idle_on = 1'b0;
      rsp_hold_left = 120;
      send_random(160);
      wait_idle();
      req_idle_on = 1'b1;
   endtask

   // Pause the sender mid-image until every pixel has come out.
   task automatic test_sender_pause();
      set_geometry(FMT_BGR24, 3, 2);
      send_random(10);
      wait_idle();
      send_random(14);
      wait_idle();
   endtask

   task automatic test_random_images();
      int w_val, h_val, total, first, pick;
      while (byte_count < ITEM_TARGET) begin
         wait_idle();
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 75) w_val = $urandom_range(1, 6);
         else if (pick < 90) w_val = $urandom_range(7, 24);
         else if (pick < 94) w_val = 0;
         else w_val = $urandom_range(4090, 8191);
         pick = $urandom_range(0, 99);
         if (pick < 70) h_val = $urandom_range(1, 3);
         else if (pick < 88) h_val = $urandom_range(4, 8);
         else if (pick < 94) h_val = 0;
         else h_val = $urandom_range(4090, 8191);
         // mostly restart on a fresh image; otherwise carry on from where we are
         if ($urandom_range(0, 7) != 0) set_geometry($urandom_range(0, 1), w_val, h_val);
         if ($urandom_range(0, 1) == 0) choose_masks();
         total = image_bytes();
         if (total <= 400) begin
            total = total * $urandom_range(1, 2);
            first = $urandom_range(0, total);
            send_random(first);
            if ($urandom_range(0, 5) == 0) wait_idle();
            send_random(total - first);
            // leave a broken image behind now and then
            if ($urandom_range(0, 3) == 0) send_random($urandom_range(1, 20));
         end else begin
            send_random($urandom_range(1, 40));
         end
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            choose_masks();
            send_random($urandom_range(1, 24));
         end
      end
      wait_idle();
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      dec_fmt        = FMT_BGR24;
      dec_width      = GEOM_W'(1);
      dec_height     = GEOM_W'(1);
      dec_red_mask   = RED_MASK_RESET;
      dec_green_mask = GREEN_MASK_RESET;
      dec_blue_mask  = BLUE_MASK_RESET;
      restart_image();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_halfword_defaults();
      test_mask_layouts();
      test_size_extremes();
      test_back_pressure();
      test_sender_pause();
      test_random_images();

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bmp_rgb_pkg.sv
sv/bmp_rgb_req_if.sv
sv/bmp_rgb_rsp_if.sv
sv/bmp_rgb_cfg.sv
sv/bmp_pixel_stream_to_rgb555_unit.sv
sv/bmp_rgb_checker.sv
bench/tb_bmp_pixel_stream_to_rgb555_unit.sv
